// File: rtl/ncnc_pkg.sv
package ncnc_pkg;

   localparam int BAND_COUNT  = 4;
   localparam int CLASS_COUNT = 5;
   localparam int BAND_W      = 10;
   localparam int CENT_W      = BAND_W * BAND_COUNT;
   localparam int DSQ_W       = 22;            // 4 * 1023^2 < 2^22
   localparam int DIST_W      = 11;            // floor sqrt < 2047
   localparam int INV_W       = 25;            // 2^24 / (d+1)
   localparam int SUM_W       = 28;
   localparam int CONF_W      = 16;
   localparam int CLASS_W     = 3;
   localparam int SQRT_STEPS  = 11;
   localparam int DIV_BITS    = 17;            // quotient bits of conf
   localparam int IDX_W       = 3;
   localparam int RSP_LATENCY = 59;

   localparam logic [CLASS_W-1:0] NATURE_CLASS = 3'd4;
   localparam logic [CLASS_W-1:0] MIXED_CLASS  = 3'd5;
   localparam logic [CONF_W-1:0]  QUIET_CONF   = 16'd52429;

   localparam logic [IDX_W-1:0] REG_QUIET = 3'd5;
   localparam logic [IDX_W-1:0] REG_MINC  = 3'd6;

   localparam logic [CENT_W-1:0] CENT_RESET [CLASS_COUNT] = '{
      40'd109737096448, 40'd109683513754, 40'd109683409408,
      40'd275414987827, 40'd495317051494};
   localparam logic [CONF_W-1:0] QUIET_RESET = 16'd10240;
   localparam logic [CONF_W-1:0] MINC_RESET  = 16'd19661;

   typedef struct packed {
      logic              valid;
      logic              quiet;
      logic [CONF_W-1:0] min_conf;
   } ctrl_type;

   // one restoring step of the floor square root
   typedef struct packed {
      logic [DSQ_W-1:0]  rem;
      logic [DIST_W-1:0] root;
   } sqrt_type;

   function automatic sqrt_type sqrt_step(sqrt_type s, logic [DSQ_W-1:0] v, int i);
      sqrt_type         r;
      logic [DSQ_W+1:0] rem2;
      logic [DSQ_W+1:0] trial;
      rem2  = {s.rem, v[2*i +: 2]};
      trial = {{(DSQ_W-DIST_W){1'b0}}, s.root, 2'b01};
      if (rem2 >= trial) begin
         r.rem  = DSQ_W'(rem2 - trial);
         r.root = {s.root[DIST_W-2:0], 1'b1};
      end else begin
         r.rem  = DSQ_W'(rem2);
         r.root = {s.root[DIST_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// File: rtl/ncnc_lane.sv
// One centroid lane: squared distance, pipelined floor sqrt, 2^24/(d+1).
module ncnc_lane import ncnc_pkg::*; (
   input  logic                      clock,
   input  logic [BAND_COUNT*BAND_W-1:0] bands,
   input  logic [CENT_W-1:0]         centroid,
   output logic [DIST_W-1:0]         distance,
   output logic [INV_W-1:0]          inv
);
   logic [DSQ_W-1:0] dsq_ff, dsq_in;
   logic [DSQ_W-1:0] val_ff [SQRT_STEPS];
   sqrt_type         sq_ff [SQRT_STEPS];
   sqrt_type         sq_in [SQRT_STEPS];
   // inverse: restoring divide of 2^24 by (d+1), one bit per stage
   localparam int DV_STEPS = INV_W;
   logic [DIST_W:0]   den_ff [DV_STEPS+1];
   logic [DIST_W:0]   rem_ff [DV_STEPS+1];
   logic [INV_W-1:0]  quo_ff [DV_STEPS+1];
   logic [DIST_W-1:0] dd_ff  [DV_STEPS+1];

   always_comb begin
      logic [BAND_W:0]   df;
      logic [DSQ_W-1:0]  acc;
      acc = '0;
      for (int k = 0; k < BAND_COUNT; k++) begin
         if (bands[k*BAND_W +: BAND_W] >= centroid[k*BAND_W +: BAND_W])
            df = {1'b0, bands[k*BAND_W +: BAND_W]} - {1'b0, centroid[k*BAND_W +: BAND_W]};
         else
            df = {1'b0, centroid[k*BAND_W +: BAND_W]} - {1'b0, bands[k*BAND_W +: BAND_W]};
         acc = acc + DSQ_W'(df * df);
      end
      dsq_in = acc;
   end

   always_comb begin
      sq_in[0] = sqrt_step('0, dsq_ff, SQRT_STEPS-1);
      for (int i = 1; i < SQRT_STEPS; i++)
         sq_in[i] = sqrt_step(sq_ff[i-1], val_ff[i-1], SQRT_STEPS-1-i);
   end

   always_ff @(posedge clock) begin
      dsq_ff    <= dsq_in;
      sq_ff[0]  <= sq_in[0];
      val_ff[0] <= dsq_ff;
      for (int i = 1; i < SQRT_STEPS; i++) begin
         sq_ff[i]  <= sq_in[i];
         val_ff[i] <= val_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      den_ff[0] <= {1'b0, sq_ff[SQRT_STEPS-1].root} + 1'b1;
      rem_ff[0] <= '0;
      quo_ff[0] <= '0;
      dd_ff[0]  <= sq_ff[SQRT_STEPS-1].root;
      for (int i = 0; i < DV_STEPS; i++) begin
         logic [DIST_W+1:0] r2;
         // dividend 2^24: bit 24 set, rest clear
         r2 = {rem_ff[i], (i == 0) ? 1'b1 : 1'b0};
         if (r2 >= {1'b0, den_ff[i]}) begin
            rem_ff[i+1] <= (DIST_W+1)'(r2 - {1'b0, den_ff[i]});
            quo_ff[i+1] <= {quo_ff[i][INV_W-2:0], 1'b1};
         end else begin
            rem_ff[i+1] <= (DIST_W+1)'(r2);
            quo_ff[i+1] <= {quo_ff[i][INV_W-2:0], 1'b0};
         end
         den_ff[i+1] <= den_ff[i];
         dd_ff[i+1]  <= dd_ff[i];
      end
   end

   assign distance = dd_ff[DV_STEPS];
   assign inv      = quo_ff[DV_STEPS];
endmodule

// File: rtl/ncnc_merge.sv
// Picks the nearest lane, sums inverses, divides best*2^16 by the sum.
module ncnc_merge import ncnc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctrl,
   input  logic [DIST_W-1:0]    distance [CLASS_COUNT],
   input  logic [INV_W-1:0]     inv  [CLASS_COUNT],
   output logic                 done,
   output logic [CLASS_W-1:0]   cls,
   output logic [CONF_W-1:0]    conf,
   output logic                 quiet
);
   // stage 0: argmin and sum
   ctrl_type           c0_ff;
   logic [CLASS_W-1:0] b0_ff;
   logic [INV_W-1:0]   bi0_ff;
   logic [SUM_W-1:0]   s0_ff;

   always_ff @(posedge clock) begin
      logic [CLASS_W-1:0] b;
      logic [DIST_W-1:0]  bd;
      logic [SUM_W-1:0]   s;
      b  = '0;
      bd = distance[0];
      s  = '0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
         s = s + SUM_W'(inv[k]);
         if (k > 0 && distance[k] < bd) begin
            bd = distance[k];
            b  = CLASS_W'(k);
         end
      end
      b0_ff  <= b;
      bi0_ff <= inv[b];
      s0_ff  <= s;
   end

   // divider: one quotient bit per stage, dividend bi*2^16
   localparam int DIVD_W = INV_W + CONF_W;
   ctrl_type           cd_ff [DIV_BITS+1];
   logic [CLASS_W-1:0] bd_ff [DIV_BITS+1];
   logic [DIVD_W-1:0]  n_ff  [DIV_BITS+1];
   logic [SUM_W-1:0]   d_ff  [DIV_BITS+1];
   logic [SUM_W:0]     r_ff  [DIV_BITS+1];
   logic [DIV_BITS-1:0] q_ff [DIV_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff.valid <= 1'b0;
         for (int i = 0; i <= DIV_BITS; i++) cd_ff[i].valid <= 1'b0;
      end else begin
         c0_ff.valid <= ctrl.valid;
         cd_ff[0].valid <= c0_ff.valid;
         for (int i = 0; i < DIV_BITS; i++) cd_ff[i+1].valid <= cd_ff[i].valid;
      end
      c0_ff.quiet    <= ctrl.quiet;
      c0_ff.min_conf <= ctrl.min_conf;
      cd_ff[0].quiet    <= c0_ff.quiet;
      cd_ff[0].min_conf <= c0_ff.min_conf;
      bd_ff[0] <= b0_ff;
      n_ff[0]  <= {bi0_ff, {CONF_W{1'b0}}};
      d_ff[0]  <= s0_ff;
      // quotient < 2^17, so top bits of remainder start from high dividend part
      r_ff[0]  <= (SUM_W+1)'({bi0_ff, {CONF_W{1'b0}}} >> DIV_BITS);
      q_ff[0]  <= '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         logic [SUM_W+1:0] r2;
         r2 = {r_ff[i], n_ff[i][DIV_BITS-1-i]};
         if (r2 >= {2'b00, d_ff[i]}) begin
            r_ff[i+1] <= (SUM_W+1)'(r2 - {2'b00, d_ff[i]});
            q_ff[i+1] <= {q_ff[i][DIV_BITS-2:0], 1'b1};
         end else begin
            r_ff[i+1] <= (SUM_W+1)'(r2);
            q_ff[i+1] <= {q_ff[i][DIV_BITS-2:0], 1'b0};
         end
         cd_ff[i+1].quiet    <= cd_ff[i].quiet;
         cd_ff[i+1].min_conf <= cd_ff[i].min_conf;
         bd_ff[i+1] <= bd_ff[i];
         n_ff[i+1]  <= n_ff[i];
         d_ff[i+1]  <= d_ff[i];
      end
   end

   // final selection
   logic [DIV_BITS-1:0] q;
   logic [CONF_W-1:0]   sat;
   assign q   = q_ff[DIV_BITS];
   assign sat = q[DIV_BITS-1] ? {CONF_W{1'b1}} : q[CONF_W-1:0];

   logic                done_ff;
   logic [CLASS_W-1:0]  cls_ff, cls_in;
   logic [CONF_W-1:0]   conf_ff, conf_in;
   logic                quiet_ff;

   always_comb begin
      if (cd_ff[DIV_BITS].quiet) begin
         cls_in  = NATURE_CLASS;
         conf_in = QUIET_CONF;
      end else if (sat < cd_ff[DIV_BITS].min_conf) begin
         cls_in  = MIXED_CLASS;
         conf_in = (sat == '0) ? {CONF_W{1'b1}} : CONF_W'(~sat + 1'b1);
      end else begin
         cls_in  = bd_ff[DIV_BITS];
         conf_in = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else       done_ff <= cd_ff[DIV_BITS].valid;
      cls_ff   <= cls_in;
      conf_ff  <= conf_in;
      quiet_ff <= cd_ff[DIV_BITS].quiet;
   end

   assign done  = done_ff;
   assign cls   = cls_ff;
   assign conf  = conf_ff;
   assign quiet = quiet_ff;
endmodule

// File: rtl/nearest_centroid_noise_classifier_top.sv
// Nearest-centroid noise classifier. A transaction is taken at every clock
// edge with start high (busy is always low: the block is fully pipelined and
// takes one transaction per cycle). Each transaction yields exactly one
// result on rsp_* with rsp_valid high for one cycle, in order, after the
// capture register, the squared distance register, the square root lanes,
// the inverse divider lanes, the argmin/sum merge, the confidence divider
// and the output register. The receiver cannot stall. Five identical lanes,
// one per class centroid, run side by side. Thresholds are sampled on
// capture and the centroids in the cycle after it, so write registers only
// while no transaction is in flight.
module nearest_centroid_noise_classifier_top import ncnc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [BAND_W-1:0]    req_band_low,
   input  logic [BAND_W-1:0]    req_band_mid_low,
   input  logic [BAND_W-1:0]    req_band_mid_high,
   input  logic [BAND_W-1:0]    req_band_high,
   input  logic [15:0]          req_total_level,
   output logic                 rsp_valid,
   output logic [CLASS_W-1:0]   rsp_source_class,
   output logic [CONF_W-1:0]    rsp_confidence,
   output logic                 rsp_quiet_flag,
   input  logic                 csr_we,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [CENT_W-1:0]    csr_wdata
);
   // configuration registers
   logic [CENT_W-1:0] cent_ff [CLASS_COUNT];
   logic [CONF_W-1:0] quiet_lvl_ff, min_conf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CLASS_COUNT; k++) cent_ff[k] <= CENT_RESET[k];
         quiet_lvl_ff <= QUIET_RESET;
         min_conf_ff  <= MINC_RESET;
      end else if (csr_we) begin
         for (int k = 0; k < CLASS_COUNT; k++)
            if (csr_index == IDX_W'(k)) cent_ff[k] <= csr_wdata;
         if (csr_index == REG_QUIET) quiet_lvl_ff <= csr_wdata[CONF_W-1:0];
         if (csr_index == REG_MINC)  min_conf_ff  <= csr_wdata[CONF_W-1:0];
      end
   end

   assign busy = 1'b0;

   // capture stage
   logic [BAND_COUNT*BAND_W-1:0] bands_ff;
   ctrl_type                     cap_ff;
   always_ff @(posedge clock) begin
      if (reset) cap_ff.valid <= 1'b0;
      else       cap_ff.valid <= start;
      cap_ff.quiet    <= req_total_level < quiet_lvl_ff;
      cap_ff.min_conf <= min_conf_ff;
      bands_ff <= {req_band_high, req_band_mid_high, req_band_mid_low, req_band_low};
   end

   // control rides alongside the lanes: 1 + 11 + 26 stages
   localparam int LANE_LAT = 1 + SQRT_STEPS + INV_W + 1;
   ctrl_type ctl_ff [LANE_LAT];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) ctl_ff[i].valid <= 1'b0;
      end else begin
         ctl_ff[0].valid <= cap_ff.valid;
         for (int i = 1; i < LANE_LAT; i++) ctl_ff[i].valid <= ctl_ff[i-1].valid;
      end
      ctl_ff[0].quiet    <= cap_ff.quiet;
      ctl_ff[0].min_conf <= cap_ff.min_conf;
      for (int i = 1; i < LANE_LAT; i++) begin
         ctl_ff[i].quiet    <= ctl_ff[i-1].quiet;
         ctl_ff[i].min_conf <= ctl_ff[i-1].min_conf;
      end
   end

   logic [DIST_W-1:0] distance [CLASS_COUNT];
   logic [INV_W-1:0]  inv  [CLASS_COUNT];

   for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_lane
      ncnc_lane u_lane (
         .clock    (clock),
         .bands    (bands_ff),
         .centroid (cent_ff[g]),
         .distance (distance[g]),
         .inv      (inv[g])
      );
   end

   ncnc_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctl_ff[LANE_LAT-1]),
      .distance (distance),
      .inv      (inv),
      .done     (rsp_valid),
      .cls      (rsp_source_class),
      .conf     (rsp_confidence),
      .quiet    (rsp_quiet_flag)
   );
endmodule

// File: rtl/ncnc_checker.sv
module ncnc_checker import ncnc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [CLASS_W-1:0] rsp_source_class,
   input logic [CONF_W-1:0]  rsp_confidence,
   input logic               rsp_quiet_flag
);
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_source_class <= MIXED_CLASS)
      else $error("class out of range");
   a_quiet_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quiet_flag |->
         rsp_source_class == NATURE_CLASS && rsp_confidence == QUIET_CONF)
      else $error("quiet result malformed");
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_no_spurious: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   // every accepted transaction must be followed by a result on rsp_valid
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##RSP_LATENCY rsp_valid)
      else $error("result missing");
endmodule

bind nearest_centroid_noise_classifier_top ncnc_checker u_chk (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_source_class,
   .rsp_confidence, .rsp_quiet_flag);
